### sv/mu8_pkg.sv
package mu8_pkg;

    localparam int ByteWidth    = 8;
    localparam int UnitWidth    = 16;
    localparam int PartialWidth = 10;
    localparam int PendWidth    = 2;

    localparam logic [ByteWidth-1:0] AsciiMask   = 8'b1000_0000;
    localparam logic [ByteWidth-1:0] Lead2Mask   = 8'b1110_0000;
    localparam logic [ByteWidth-1:0] Lead2Code   = 8'b1100_0000;
    localparam logic [ByteWidth-1:0] Lead3Mask   = 8'b1111_0000;
    localparam logic [ByteWidth-1:0] Lead3Code   = 8'b1110_0000;
    localparam logic [ByteWidth-1:0] Lead2Data   = 8'h1f;
    localparam logic [ByteWidth-1:0] Lead3Data   = 8'h0f;
    localparam logic [ByteWidth-1:0] ContData    = 8'h3f;

    localparam logic [PendWidth-1:0] PendNone = 2'd0;
    localparam logic [PendWidth-1:0] PendOne  = 2'd1;
    localparam logic [PendWidth-1:0] PendTwo  = 2'd2;

    typedef struct packed {
        logic                    emit;
        logic [UnitWidth-1:0]    code_unit;
        logic                    error;
        logic                    last;
        logic [PendWidth-1:0]    pending;
        logic [PartialWidth-1:0] partial;
    } dec_result_t;

endpackage

### sv/mu8_in_stage.sv
module mu8_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mu8_pkg::ByteWidth-1:0]  s_tdata,   // byte_in
    input  logic                           s_tlast,   // end_of_string
    input  logic                           advance,
    output logic                           in_valid,
    output logic [mu8_pkg::ByteWidth-1:0]  in_byte,
    output logic                           in_eos
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [mu8_pkg::ByteWidth-1:0] byte_reg;
    logic                          eos_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            eos_reg  <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_eos   = eos_reg;

endmodule

### sv/mu8_decode.sv
module mu8_decode
(
    input  logic [mu8_pkg::ByteWidth-1:0]    in_byte,
    input  logic                             in_eos,
    input  logic [mu8_pkg::PendWidth-1:0]    pending,
    input  logic [mu8_pkg::PartialWidth-1:0] partial,
    output mu8_pkg::dec_result_t             res
);

    logic [mu8_pkg::UnitWidth-1:0] acc;
    logic [mu8_pkg::PendWidth-1:0] pend_dec;
    logic [mu8_pkg::ByteWidth-1:0] cont_bits;

    assign cont_bits = in_byte & mu8_pkg::ContData;
    assign acc       = {partial, cont_bits[5:0]};
    assign pend_dec  = pending - mu8_pkg::PendOne;

    always_comb
    begin
        res           = '0;
        res.last      = in_eos;
        res.pending   = mu8_pkg::PendNone;
        res.partial   = '0;
        if (pending != mu8_pkg::PendNone)
        begin
            // continuation byte, not checked
            if (pend_dec == mu8_pkg::PendNone)
            begin
                res.emit      = 1'b1;
                res.code_unit = acc;
            end
            else if (in_eos)
            begin
                res.emit  = 1'b1;
                res.error = 1'b1;
            end
            else
            begin
                res.pending = pend_dec;
                res.partial = acc[mu8_pkg::PartialWidth-1:0];
            end
        end
        else if ((in_byte & mu8_pkg::AsciiMask) == '0)
        begin
            res.emit = 1'b1;
            if (in_byte == '0)
            begin
                res.error = 1'b1;
            end
            else
            begin
                res.code_unit = {{(mu8_pkg::UnitWidth-mu8_pkg::ByteWidth){1'b0}}, in_byte};
            end
        end
        else if ((in_byte & mu8_pkg::Lead2Mask) == mu8_pkg::Lead2Code ||
                 (in_byte & mu8_pkg::Lead3Mask) == mu8_pkg::Lead3Code)
        begin
            if (in_eos)
            begin
                // string ends on a lead byte
                res.emit  = 1'b1;
                res.error = 1'b1;
            end
            else if ((in_byte & mu8_pkg::Lead2Mask) == mu8_pkg::Lead2Code)
            begin
                res.pending = mu8_pkg::PendOne;
                res.partial = {2'b00, in_byte & mu8_pkg::Lead2Data};
            end
            else
            begin
                res.pending = mu8_pkg::PendTwo;
                res.partial = {2'b00, in_byte & mu8_pkg::Lead3Data};
            end
        end
        else
        begin
            // stray continuation or 1111xxxx lead
            res.emit  = 1'b1;
            res.error = 1'b1;
        end
    end

endmodule

### sv/mu8_out_stage.sv
module mu8_out_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  mu8_pkg::dec_result_t            res,
    output logic                            advance,
    output logic [mu8_pkg::PendWidth-1:0]   pending,
    output logic [mu8_pkg::PartialWidth-1:0] partial,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mu8_pkg::UnitWidth-1:0]   m_tdata,   // code_unit
    output logic                            m_tuser,   // error
    output logic                            m_tlast    // last
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [mu8_pkg::UnitWidth-1:0]    unit_reg;
    logic                             err_reg;
    logic                             last_reg;
    logic [mu8_pkg::PendWidth-1:0]    pending_reg;
    logic [mu8_pkg::PartialWidth-1:0] partial_reg;

    // a byte moves on when the result slot is free or being drained
    assign advance = in_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg && !m_tready;
        if (advance)
        begin
            valid_next = res.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= mu8_pkg::PendNone;
            partial_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (advance)
            begin
                pending_reg <= res.pending;
                partial_reg <= res.partial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            unit_reg <= res.code_unit;
            err_reg  <= res.error;
            last_reg <= res.last;
        end
    end

    assign pending  = pending_reg;
    assign partial  = partial_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = unit_reg;
    assign m_tuser  = err_reg;
    assign m_tlast  = last_reg;

endmodule

### sv/modified_utf8_to_utf16_decoder_unit.sv
// modified utf-8 to utf-16 decoder
// input stream s_*: one byte per word in s_tdata, s_tlast marks the last byte
//   of a string
// output stream m_*: one utf-16 code unit per word in m_tdata, m_tuser is the
//   error flag (code unit reads zero then), m_tlast follows the byte that
//   caused the word
// a word appears only when a 1-, 2- or 3-byte sequence completes, or on a
//   zero byte, a bad lead byte or a string cut short; lead bytes give no word
// throughput: one byte per cycle, sustained, with m_tready high
// an accepted byte is held in the input register, decoded from there, and
//   its word is registered in the result register, which drives m_*
// the decode state (continuation bytes due, partial value) sits beside the
//   result register and is updated as each byte leaves the input register
// reset clears both stages and the decode state; no word is pending after it
// when m_tready is low the result register holds its word, one more byte waits
//   in the input register and s_tready then drops
module modified_utf8_to_utf16_decoder_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mu8_pkg::ByteWidth-1:0]  s_tdata,   // byte_in
    input  logic                           s_tlast,   // end_of_string
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mu8_pkg::UnitWidth-1:0]  m_tdata,   // code_unit
    output logic                           m_tuser,   // error
    output logic                           m_tlast    // last
);

    logic                             advance;
    logic                             in_valid;
    logic [mu8_pkg::ByteWidth-1:0]    in_byte;
    logic                             in_eos;
    logic [mu8_pkg::PendWidth-1:0]    pending;
    logic [mu8_pkg::PartialWidth-1:0] partial;
    mu8_pkg::dec_result_t             res;

    mu8_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_eos   (in_eos)
    );

    mu8_decode u_dec
    (
        .in_byte (in_byte),
        .in_eos  (in_eos),
        .pending (pending),
        .partial (partial),
        .res     (res)
    );

    mu8_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .res      (res),
        .advance  (advance),
        .pending  (pending),
        .partial  (partial),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/mu8_checker.sv
module mu8_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mu8_pkg::UnitWidth-1:0]  m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast
);

    // error words carry a zero code unit
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error word with nonzero code unit");

    // an empty result stage never back-pressures the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("word offered out of reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
            $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled word changed");

endmodule

bind modified_utf8_to_utf16_decoder_unit mu8_checker u_mu8_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
